FILE: rtl/core/sit_pkg.sv
// Shared types for the segment intersection test core.
`default_nettype none

package sit_pkg;

    // Sign of one orientation product pair, plus the closed-extent test on its differences.
    typedef struct packed {
        logic pos;
        logic zero;
        logic in_extent;
    } orient_t;

endpackage

`default_nettype wire

FILE: rtl/core/sit_orient.sv
// Orientation sign and extent test for one point against a segment, from registered differences.
`default_nettype none

module sit_orient #(
    parameter int DIFF_WIDTH = 17
) (
    input  wire logic signed [DIFF_WIDTH-1:0] dax,
    input  wire logic signed [DIFF_WIDTH-1:0] day,
    input  wire logic signed [DIFF_WIDTH-1:0] dbx,
    input  wire logic signed [DIFF_WIDTH-1:0] dby,
    output sit_pkg::orient_t                  result
);

    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;

    logic signed [PROD_WIDTH-1:0] prod_a;
    logic signed [PROD_WIDTH-1:0] prod_b;
    logic                         x_outside;
    logic                         y_outside;

    assign prod_a = PROD_WIDTH'(dax) * PROD_WIDTH'(dby);
    assign prod_b = PROD_WIDTH'(dbx) * PROD_WIDTH'(day);

    // Outside the extent when both ends lie strictly on one side of the point.
    assign x_outside = ((dax > 0) && (dbx > 0)) || ((dax < 0) && (dbx < 0));
    assign y_outside = ((day > 0) && (dby > 0)) || ((day < 0) && (dby < 0));

    assign result.pos       = prod_a > prod_b;
    assign result.zero      = prod_a == prod_b;
    assign result.in_extent = !x_outside && !y_outside;

endmodule

`default_nettype wire

FILE: rtl/core/segment_intersection_test_core.sv
// Top level of the segment intersection test core.
//
//   channel   direction  handshake             payload
//   request   in         start, busy           u_start_x .. v_end_y (COORD_WIDTH each)
//   result    out        done (strobe)         touch_or_cross, proper_cross
//
// One request per cycle; busy stays low. Each request passes through registers to its result:
// the first register holds the sixteen coordinate differences, the second the flags.
// The critical path is one (COORD_WIDTH+1)-bit multiply and its compare.
// Reset clears the valid bits only. The result strobe lasts one cycle and cannot be held.
`default_nettype none

module segment_intersection_test_core #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic signed [COORD_WIDTH-1:0] u_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] u_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] u_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] u_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] v_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] v_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] v_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] v_end_y,
    output      logic                          done,
    output      logic                          touch_or_cross,
    output      logic                          proper_cross
);

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int NUM_ORIENT = 4;

    // Orientation tests: U against V's start, U against V's end,
    // V against U's start, V against U's end.
    localparam int OR_U_VS = 0;
    localparam int OR_U_VE = 1;
    localparam int OR_V_US = 2;
    localparam int OR_V_UE = 3;

    logic signed [COORD_WIDTH-1:0] ax   [NUM_ORIENT];
    logic signed [COORD_WIDTH-1:0] ay   [NUM_ORIENT];
    logic signed [COORD_WIDTH-1:0] bx   [NUM_ORIENT];
    logic signed [COORD_WIDTH-1:0] by_c [NUM_ORIENT];
    logic signed [COORD_WIDTH-1:0] cx   [NUM_ORIENT];
    logic signed [COORD_WIDTH-1:0] cy   [NUM_ORIENT];

    logic signed [DIFF_WIDTH-1:0] dax_next [NUM_ORIENT];
    logic signed [DIFF_WIDTH-1:0] day_next [NUM_ORIENT];
    logic signed [DIFF_WIDTH-1:0] dbx_next [NUM_ORIENT];
    logic signed [DIFF_WIDTH-1:0] dby_next [NUM_ORIENT];
    logic signed [DIFF_WIDTH-1:0] dax_reg  [NUM_ORIENT];
    logic signed [DIFF_WIDTH-1:0] day_reg  [NUM_ORIENT];
    logic signed [DIFF_WIDTH-1:0] dbx_reg  [NUM_ORIENT];
    logic signed [DIFF_WIDTH-1:0] dby_reg  [NUM_ORIENT];

    sit_pkg::orient_t orient [NUM_ORIENT];

    logic accept;
    logic stage_valid_reg;
    logic done_reg;
    logic touch_reg;
    logic proper_reg;
    logic touch_next;
    logic proper_next;
    logic general;
    logic u_same_side;
    logic v_same_side;
    logic u_opp_side;
    logic v_opp_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        ax[OR_U_VS] = u_start_x; ay[OR_U_VS] = u_start_y;
        bx[OR_U_VS] = u_end_x;   by_c[OR_U_VS] = u_end_y;
        cx[OR_U_VS] = v_start_x; cy[OR_U_VS] = v_start_y;

        ax[OR_U_VE] = u_start_x; ay[OR_U_VE] = u_start_y;
        bx[OR_U_VE] = u_end_x;   by_c[OR_U_VE] = u_end_y;
        cx[OR_U_VE] = v_end_x;   cy[OR_U_VE] = v_end_y;

        ax[OR_V_US] = v_start_x; ay[OR_V_US] = v_start_y;
        bx[OR_V_US] = v_end_x;   by_c[OR_V_US] = v_end_y;
        cx[OR_V_US] = u_start_x; cy[OR_V_US] = u_start_y;

        ax[OR_V_UE] = v_start_x; ay[OR_V_UE] = v_start_y;
        bx[OR_V_UE] = v_end_x;   by_c[OR_V_UE] = v_end_y;
        cx[OR_V_UE] = u_end_x;   cy[OR_V_UE] = u_end_y;
    end

    for (genvar i = 0; i < NUM_ORIENT; i++)
    begin : g_orient
        assign dax_next[i] = DIFF_WIDTH'(ax[i]) - DIFF_WIDTH'(cx[i]);
        assign day_next[i] = DIFF_WIDTH'(ay[i]) - DIFF_WIDTH'(cy[i]);
        assign dbx_next[i] = DIFF_WIDTH'(bx[i]) - DIFF_WIDTH'(cx[i]);
        assign dby_next[i] = DIFF_WIDTH'(by_c[i]) - DIFF_WIDTH'(cy[i]);

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                dax_reg[i] <= dax_next[i];
                day_reg[i] <= day_next[i];
                dbx_reg[i] <= dbx_next[i];
                dby_reg[i] <= dby_next[i];
            end
        end

        sit_orient #(
            .DIFF_WIDTH (DIFF_WIDTH)
        ) u_orient (
            .dax    (dax_reg[i]),
            .day    (day_reg[i]),
            .dbx    (dbx_reg[i]),
            .dby    (dby_reg[i]),
            .result (orient[i])
        );
    end

    always_comb
    begin
        general = !orient[OR_U_VS].zero || !orient[OR_U_VE].zero;

        u_same_side = (orient[OR_V_US].pos && orient[OR_V_UE].pos)
                   || (!orient[OR_V_US].pos && !orient[OR_V_US].zero
                       && !orient[OR_V_UE].pos && !orient[OR_V_UE].zero);
        v_same_side = (orient[OR_U_VS].pos && orient[OR_U_VE].pos)
                   || (!orient[OR_U_VS].pos && !orient[OR_U_VS].zero
                       && !orient[OR_U_VE].pos && !orient[OR_U_VE].zero);
        u_opp_side  = (orient[OR_V_US].pos && !orient[OR_V_UE].pos && !orient[OR_V_UE].zero)
                   || (orient[OR_V_UE].pos && !orient[OR_V_US].pos && !orient[OR_V_US].zero);
        v_opp_side  = (orient[OR_U_VS].pos && !orient[OR_U_VE].pos && !orient[OR_U_VE].zero)
                   || (orient[OR_U_VE].pos && !orient[OR_U_VS].pos && !orient[OR_U_VS].zero);

        if (general)
        begin
            touch_next = !u_same_side && !v_same_side;
        end
        else
        begin
            touch_next = (orient[OR_U_VS].zero && orient[OR_U_VS].in_extent)
                      || (orient[OR_U_VE].zero && orient[OR_U_VE].in_extent)
                      || (orient[OR_V_US].zero && orient[OR_V_US].in_extent)
                      || (orient[OR_V_UE].zero && orient[OR_V_UE].in_extent);
        end

        proper_next = u_opp_side && v_opp_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
            done_reg        <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            touch_reg  <= touch_next;
            proper_reg <= proper_next;
        end
    end

    assign done           = done_reg;
    assign touch_or_cross = touch_reg;
    assign proper_cross   = proper_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sit_checker.sv
// Port-level checks for the segment intersection test core, bound to the top level.
`default_nettype none

module sit_checker #(
    parameter int COORD_WIDTH = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic signed [COORD_WIDTH-1:0] u_start_x,
    input wire logic signed [COORD_WIDTH-1:0] u_start_y,
    input wire logic signed [COORD_WIDTH-1:0] u_end_x,
    input wire logic signed [COORD_WIDTH-1:0] u_end_y,
    input wire logic signed [COORD_WIDTH-1:0] v_start_x,
    input wire logic signed [COORD_WIDTH-1:0] v_start_y,
    input wire logic signed [COORD_WIDTH-1:0] v_end_x,
    input wire logic signed [COORD_WIDTH-1:0] v_end_y,
    input wire logic                          done,
    input wire logic                          touch_or_cross,
    input wire logic                          proper_cross
);

    logic same_segs;
    logic u_point;

    assign same_segs = (u_start_x == v_start_x) && (u_start_y == v_start_y)
                    && (u_end_x == v_end_x) && (u_end_y == v_end_y);
    assign u_point   = (u_start_x == u_end_x) && (u_start_y == u_end_y);

    // Every strobe answers a request that the core took.
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, 2))
        else $error("result strobe without a request");

    // Every request taken out of reset yields a strobe.
    a_request_has_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy && rst_n, 2) && $past(rst_n, 1)) |-> done)
        else $error("request lost");

    // A strict crossing is always a touch.
    a_proper_implies_touch: assert property (@(posedge clk) disable iff (!rst_n)
        (done && proper_cross) |-> touch_or_cross)
        else $error("proper crossing without touch");

    // Identical segments touch and never cross strictly.
    a_identical_segments: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(same_segs, 2)) |-> (touch_or_cross && !proper_cross))
        else $error("identical segments misjudged");

    // A point-like first segment never crosses strictly.
    a_point_no_proper: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(u_point, 2)) |-> !proper_cross)
        else $error("degenerate segment crosses");

endmodule

bind segment_intersection_test_core sit_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_sit_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .u_start_x      (u_start_x),
    .u_start_y      (u_start_y),
    .u_end_x        (u_end_x),
    .u_end_y        (u_end_y),
    .v_start_x      (v_start_x),
    .v_start_y      (v_start_y),
    .v_end_x        (v_end_x),
    .v_end_y        (v_end_y),
    .done           (done),
    .touch_or_cross (touch_or_cross),
    .proper_cross   (proper_cross)
);

`default_nettype wire

FILE: tb/segment_intersection_test_core_tb.sv
// Testbench for the segment intersection test core: directed and random segment pairs.
`timescale 1ns / 1ps

module segment_intersection_test_core_tb;

    localparam int W = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PAIRS = 1730;

    typedef struct {
        logic signed [W-1:0] ux0, uy0, ux1, uy1, vx0, vy0, vx1, vy1;
        bit                  wait_drain;
    } seg_pair_t;

    typedef struct {
        logic touch;
        logic proper;
        bit   aligned;
    } flags_t;

    typedef struct {
        longint x;
        longint y;
    } pt_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic signed [W-1:0] u_start_x, u_start_y, u_end_x, u_end_y;
    logic signed [W-1:0] v_start_x, v_start_y, v_end_x, v_end_y;
    logic                done;
    logic                touch_or_cross;
    logic                proper_cross;

    seg_pair_t pair_q[$];
    flags_t    flags_q[$];
    logic      taken;
    int        n_total;
    int        n_sent;
    int        n_accepted;
    int        n_results;
    int        n_touch;
    int        n_proper;
    int        n_aligned;
    int        n_errors;
    int        cycles;

    segment_intersection_test_core #(
        .COORD_WIDTH(W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .u_start_x     (u_start_x),
        .u_start_y     (u_start_y),
        .u_end_x       (u_end_x),
        .u_end_y       (u_end_y),
        .v_start_x     (v_start_x),
        .v_start_y     (v_start_y),
        .v_end_x       (v_end_x),
        .v_end_y       (v_end_y),
        .done          (done),
        .touch_or_cross(touch_or_cross),
        .proper_cross  (proper_cross)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int turn_dir(pt_t a, pt_t b, pt_t c);
        longint p1, p2;
        p1 = (a.x - c.x) * (b.y - c.y);
        p2 = (b.x - c.x) * (a.y - c.y);
        return (p1 > p2) ? 1 : ((p1 < p2) ? -1 : 0);
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit lies_on(pt_t p, pt_t a, pt_t b);
        return turn_dir(p, a, b) == 0
            && sign_of(a.x - p.x) * sign_of(b.x - p.x) <= 0
            && sign_of(a.y - p.y) * sign_of(b.y - p.y) <= 0;
    endfunction

    function automatic int side_product(pt_t p, pt_t q, pt_t a, pt_t b);
        return turn_dir(a, p, b) * turn_dir(a, q, b);
    endfunction

    function automatic flags_t predict_flags(seg_pair_t r);
        pt_t    ua, ub, va, vb;
        flags_t f;
        ua.x = r.ux0; ua.y = r.uy0;
        ub.x = r.ux1; ub.y = r.uy1;
        va.x = r.vx0; va.y = r.vy0;
        vb.x = r.vx1; vb.y = r.vy1;
        f.aligned = turn_dir(ua, ub, va) == 0 && turn_dir(ua, ub, vb) == 0;
        if (!f.aligned)
            f.touch = side_product(ua, ub, va, vb) <= 0 && side_product(va, vb, ua, ub) <= 0;
        else
            f.touch = lies_on(ua, va, vb) || lies_on(ub, va, vb)
                   || lies_on(va, ua, ub) || lies_on(vb, ua, ub);
        f.proper = side_product(ua, ub, va, vb) < 0 && side_product(va, vb, ua, ub) < 0;
        return f;
    endfunction

    function automatic int rnd_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic add_pair(int ux0, int uy0, int ux1, int uy1,
                            int vx0, int vy0, int vx1, int vy1, bit drain);
        seg_pair_t r;
        r.ux0 = ux0[W-1:0]; r.uy0 = uy0[W-1:0]; r.ux1 = ux1[W-1:0]; r.uy1 = uy1[W-1:0];
        r.vx0 = vx0[W-1:0]; r.vy0 = vy0[W-1:0]; r.vx1 = vx1[W-1:0]; r.vy1 = vy1[W-1:0];
        r.wait_drain = drain;
        pair_q.push_back(r);
    endtask

    task automatic add_random(bit drain);
        int c[8];
        int px, py, dx, dy, s, ox, oy, span, which;
        case ($urandom_range(5))
            0:
            begin
                foreach (c[i]) c[i] = int'($urandom() & 32'hffff);
            end
            1:
            begin
                foreach (c[i]) c[i] = rnd_in(-6, 6);
            end
            2, 5:
            begin
                span = $urandom_range(1) ? 8000 : 3;
                px = rnd_in(-700, 700); py = rnd_in(-700, 700);
                dx = rnd_in(-span, span); dy = rnd_in(-span, span);
                for (int i = 0; i < 4; i++)
                begin
                    s = rnd_in(-4, 4);
                    c[2*i] = px + s * dx;
                    c[2*i+1] = py + s * dy;
                end
                if ($urandom_range(3) == 0)
                    c[5] = c[5] + rnd_in(-1, 1);
                which = $urandom_range(1);
                if ($urandom_range(1))
                begin
                    c[4*which+2] = c[4*which];
                    c[4*which+3] = c[4*which+1];
                end
            end
            3:
            begin
                span = $urandom_range(1) ? 32767 : 20;
                foreach (c[i]) c[i] = rnd_in(-span - 1, span);
                which = $urandom_range(3);
                c[4 + 2*(which % 2)] = c[2*(which / 2)];
                c[5 + 2*(which % 2)] = c[2*(which / 2) + 1];
            end
            default:
            begin
                s = rnd_in(1, 10000);
                ox = rnd_in(-2000, 2000); oy = rnd_in(-2000, 2000);
                for (int i = 0; i < 4; i++)
                begin
                    c[2*i] = ox + s * rnd_in(-3, 3);
                    c[2*i+1] = oy + s * rnd_in(-3, 3);
                end
            end
        endcase
        add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], drain);
    endtask

    task automatic report_mismatch(string what, flags_t want);
        $display("ERROR cycle %0d: %s (touch_or_cross %0b/%0b, proper_cross %0b/%0b)",
                 cycles, what, touch_or_cross, want.touch, proper_cross, want.proper);
        n_errors++;
    endtask

    always @(negedge clk)
    begin : drive_proc
        seg_pair_t nxt;
        int        idle_pct;
        if (rst_n && (!start || taken))
        begin
            idle_pct = (n_sent < n_total / 3) ? 13 : ((n_sent < 2 * n_total / 3) ? 81 : 0);
            if (pair_q.size() == 0 || (pair_q[0].wait_drain && flags_q.size() != 0)
                    || $urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
            end
            else
            begin
                nxt = pair_q.pop_front();
                start     <= 1'b1;
                u_start_x <= nxt.ux0;
                u_start_y <= nxt.uy0;
                u_end_x   <= nxt.ux1;
                u_end_y   <= nxt.uy1;
                v_start_x <= nxt.vx0;
                v_start_y <= nxt.vy0;
                v_end_x   <= nxt.vx1;
                v_end_y   <= nxt.vy1;
                n_sent++;
            end
        end
    end

    always @(posedge clk)
    begin : watch_proc
        seg_pair_t cur;
        flags_t    want;
        if (!rst_n)
        begin
            taken <= 1'b0;
        end
        else
        begin
            cycles++;
            if (done)
            begin
                n_results++;
                if (flags_q.size() == 0)
                begin
                    want.touch = 1'bx;
                    want.proper = 1'bx;
                    report_mismatch("result with no request pending", want);
                end
                else
                begin
                    want = flags_q.pop_front();
                    if (touch_or_cross !== want.touch)
                        report_mismatch("touch_or_cross mismatch", want);
                    if (proper_cross !== want.proper)
                        report_mismatch("proper_cross mismatch", want);
                end
            end
            taken <= start && !busy;
            if (start && !busy)
            begin
                cur.ux0 = u_start_x; cur.uy0 = u_start_y;
                cur.ux1 = u_end_x;   cur.uy1 = u_end_y;
                cur.vx0 = v_start_x; cur.vy0 = v_start_y;
                cur.vx1 = v_end_x;   cur.vy1 = v_end_y;
                cur.wait_drain = 1'b0;
                want = predict_flags(cur);
                flags_q.push_back(want);
                n_accepted++;
                n_touch += want.touch;
                n_proper += want.proper;
                n_aligned += want.aligned;
            end
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("segment_intersection_test_core test failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        taken = 1'b0;
        u_start_x = '0; u_start_y = '0; u_end_x = '0; u_end_y = '0;
        v_start_x = '0; v_start_y = '0; v_end_x = '0; v_end_y = '0;
        n_sent = 0; n_accepted = 0; n_results = 0; n_errors = 0; cycles = 0;
        n_touch = 0; n_proper = 0; n_aligned = 0;

        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_pair(-10, -10, 10, 10, -10, 10, 10, -10, 1'b0);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1'b0);
        add_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 1'b0);
        add_pair(0, 0, 5, 5, 5, 5, 10, 0, 1'b0);
        add_pair(0, 0, 10, 0, 5, 0, 15, 0, 1'b0);
        add_pair(0, 0, 4, 4, 5, 5, 9, 9, 1'b0);
        add_pair(0, 0, 4, 4, 4, 4, 8, 8, 1'b0);
        add_pair(0, -5, 0, 5, 0, 5, 0, 9, 1'b0);
        add_pair(0, 0, 10, 0, 0, 1, 10, 1, 1'b1);
        add_pair(0, 0, 10, 0, 5, 0, 5, 7, 1'b0);
        add_pair(0, 0, 10, 0, 3, 0, 3, 0, 1'b0);
        add_pair(0, 0, 10, 0, 3, 1, 3, 1, 1'b0);
        add_pair(0, 0, 10, 0, 20, 0, 20, 0, 1'b0);
        add_pair(1, 1, 1, 1, 0, 0, 2, 0, 1'b0);
        add_pair(1, 0, 1, 0, 0, 0, 2, 0, 1'b0);
        add_pair(2, 3, 2, 3, -4, 7, -4, 7, 1'b0);
        add_pair(0, 0, 2, 2, 5, 0, 4, 1, 1'b0);
        add_pair(-32768, -32768, 32767, 32767, -1, -1, 0, 0, 1'b0);
        add_pair(-32768, -32767, 32767, 32767, 0, 0, 0, 0, 1'b0);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
        add_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 1'b0);
        for (int i = 0; i < RANDOM_PAIRS; i++)
            add_random(i % 250 == 125);
        n_total = pair_q.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < n_total)
            @(posedge clk);
        while (flags_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d segment pairs in %0d cycles, %0d results checked",
                 n_accepted, cycles, n_results);
        $display("touching %0d, proper crossings %0d, collinear cases %0d, errors %0d",
                 n_touch, n_proper, n_aligned, n_errors);
        if (n_errors == 0)
            $display("segment_intersection_test_core test passed");
        else
            $display("segment_intersection_test_core test failed");
        $finish;
    end

endmodule
